@@ src/chu_pkg.sv @@
package chu_pkg;

	// Field and datapath widths
	localparam int FW           = 16;  // input fields
	localparam int HW           = 16;  // heading
	localparam int DW           = 18;  // projected difference
	localparam int CW           = 17;  // current difference
	localparam int PW           = 37;  // sum of squares
	localparam int XW           = 34;  // CORDIC x/y
	localparam int ZW           = 28;  // CORDIC angle, Q.24

	localparam int CORDIC_STEPS   = 16;
	localparam int ATAN_TABLE_LEN = 24;
	localparam int CORDIC_ITERS   = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
	                                                                : ATAN_TABLE_LEN;
	localparam int ATAN_IW        = $clog2(ATAN_TABLE_LEN);

	localparam int PRESCALE_SHIFT = 12;
	localparam int ROUND_SHIFT    = 11;
	localparam int ROUND_BIAS     = 1024;
	localparam int PI_Q24         = 52707179;
	localparam int HEADING_MAX    = 25736;

	typedef struct packed {
		logic                 apart;
		logic                 force_zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} chu_rot_t;

	// atan(2^-i) in Q.24, rounded
	function automatic logic signed [ZW-1:0] atan_q24(input logic [ATAN_IW-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = ZW'(13176795);
			5'd1:    v = ZW'(7778716);
			5'd2:    v = ZW'(4110060);
			5'd3:    v = ZW'(2086331);
			5'd4:    v = ZW'(1047214);
			5'd5:    v = ZW'(524117);
			5'd6:    v = ZW'(262123);
			5'd7:    v = ZW'(131069);
			5'd8:    v = ZW'(65536);
			5'd9:    v = ZW'(32768);
			5'd10:   v = ZW'(16384);
			5'd11:   v = ZW'(8192);
			5'd12:   v = ZW'(4096);
			5'd13:   v = ZW'(2048);
			5'd14:   v = ZW'(1024);
			5'd15:   v = ZW'(512);
			5'd16:   v = ZW'(256);
			5'd17:   v = ZW'(128);
			5'd18:   v = ZW'(64);
			5'd19:   v = ZW'(32);
			5'd20:   v = ZW'(16);
			5'd21:   v = ZW'(8);
			5'd22:   v = ZW'(4);
			5'd23:   v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

	// One vectoring micro-rotation; k is a constant at each call site
	function automatic chu_rot_t cordic_iter(input chu_rot_t r, input int k);
		chu_rot_t             o;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		xs = r.x >>> k;
		ys = r.y >>> k;
		o.apart      = r.apart;
		o.force_zero = r.force_zero;
		if (!r.y[XW-1]) begin
			o.x = r.x + ys;
			o.y = r.y - xs;
			o.z = r.z + atan_q24(ATAN_IW'(k));
		end else begin
			o.x = r.x - ys;
			o.y = r.y + xs;
			o.z = r.z - atan_q24(ATAN_IW'(k));
		end
		return o;
	endfunction

endpackage

@@ src/chu_ifs.sv @@
interface chu_in_if;
	import chu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [FW-1:0] other_x;
	logic signed [FW-1:0] other_y;
	logic signed [FW-1:0] other_vx;
	logic signed [FW-1:0] other_vy;
	logic signed [FW-1:0] own_x;
	logic signed [FW-1:0] own_y;
	logic signed [FW-1:0] own_step_x;
	logic signed [FW-1:0] own_step_y;

	modport source (output valid, other_x, other_y, other_vx, other_vy,
	                own_x, own_y, own_step_x, own_step_y, input ready);
	modport sink   (input valid, other_x, other_y, other_vx, other_vy,
	                own_x, own_y, own_step_x, own_step_y, output ready);
endinterface

interface chu_out_if;
	import chu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 diverging;
	logic signed [HW-1:0] heading;

	modport source (output valid, diverging, heading, input ready);
	modport sink   (input valid, diverging, heading, output ready);
endinterface

@@ src/collision_heading_unit_top.sv @@
// Collision heading unit: for each neighbor report, projects both drones one step ahead and
// flags diverging when the projected squared distance exceeds the current one; otherwise
// it returns atan2 of the own-minus-other projected offset as a Q3.13 heading in radians,
// clamped to +/-25736. Fully pipelined: one report per clock while the result is not stalled;
// a report passes three geometry stages (difference, square, compare), one stage per CORDIC
// micro-rotation and one round/clamp output register. Each stage holds under backpressure
// only while it is occupied, so bubbles collapse.
module collision_heading_unit_top
	import chu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	chu_in_if.sink    report,
	chu_out_if.source result
);

	logic     g_valid;
	logic     g_ready;
	chu_rot_t g_rot;
	logic     zero_head;
	logic     nc_q;
	logic     rdy_out;

	chu_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.rot_valid (g_valid),
		.rot_ready (g_ready),
		.rot       (g_rot)
	);

	chu_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot_valid (g_valid),
		.rot_ready (g_ready),
		.rot       (g_rot),
		.nc_flag   (zero_head),
		.result    (result)
	);

	// Advance the diverging flag with the heading register; coincident points
	// give a zero heading but leave the flag low.
	assign rdy_out = !result.valid || result.ready;

	always_ff @(posedge clk) begin
		if (rdy_out) nc_q <= zero_head;
	end

	assign result.diverging = nc_q && result.valid;

`ifndef SYNTHESIS
	a_nc_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.diverging |-> result.heading == '0)
		else $error("heading nonzero with diverging");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.heading <= HW'(HEADING_MAX)) &&
		                 (result.heading >= -HW'(HEADING_MAX)))
		else $error("heading out of range");

	a_geom_hold: assert property (@(posedge clk) disable iff (!arst_n)
		g_valid && !g_ready |=> g_valid && $stable(g_rot))
		else $error("geometry stage dropped a stalled request");
`endif

endmodule

@@ src/chu_geom.sv @@
module chu_geom
	import chu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	chu_in_if.sink       report,
	output logic         rot_valid,
	input  logic         rot_ready,
	output chu_rot_t     rot
);

	logic                 v_s1, v_s2, v_s3;
	logic                 en1, en2, en3;
	logic signed [DW-1:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [CW-1:0] cx_s1, cy_s1;
	logic signed [2*DW-1:0] dxx_s2, dyy_s2;
	logic signed [2*CW-1:0] cxx_s2, cyy_s2;
	logic signed [PW-1:0] proj2, cur2;
	logic signed [XW-1:0] x0, y0;
	chu_rot_t             init;
	chu_rot_t             rot_s3;

	assign en3 = !v_s3 || rot_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign report.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= report.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Differences of projected and current positions
	always_ff @(posedge clk) begin
		if (en1 && report.valid) begin
			dx_s1 <= (DW'(report.own_x) + DW'(report.own_step_x))
			       - (DW'(report.other_x) + DW'(report.other_vx));
			dy_s1 <= (DW'(report.own_y) + DW'(report.own_step_y))
			       - (DW'(report.other_y) + DW'(report.other_vy));
			cx_s1 <= CW'(report.other_x) - CW'(report.own_x);
			cy_s1 <= CW'(report.other_y) - CW'(report.own_y);
		end
	end

	// Squares
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			cxx_s2 <= cx_s1 * cx_s1;
			cyy_s2 <= cy_s1 * cy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
		end
	end

	// Distance test and CORDIC start vector (fold left half plane by +/-pi)
	always_comb begin
		proj2 = PW'(dxx_s2) + PW'(dyy_s2);
		cur2  = PW'(cxx_s2) + PW'(cyy_s2);
		x0    = XW'(dx_s2) <<< PRESCALE_SHIFT;
		y0    = XW'(dy_s2) <<< PRESCALE_SHIFT;
		init.apart      = proj2 > cur2;
		init.force_zero = init.apart || (dx_s2 == '0 && dy_s2 == '0);
		if (dx_s2[DW-1]) begin
			init.x = -x0;
			init.y = -y0;
			init.z = dy_s2[DW-1] ? -ZW'(PI_Q24) : ZW'(PI_Q24);
		end else begin
			init.x = x0;
			init.y = y0;
			init.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) rot_s3 <= init;
	end

	assign rot_valid = v_s3;
	assign rot       = rot_s3;

endmodule

@@ src/chu_cordic.sv @@
module chu_cordic
	import chu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rot_valid,
	output logic     rot_ready,
	input  chu_rot_t rot,
	output logic     nc_flag,
	chu_out_if.source result
);

	logic     stage_v   [CORDIC_ITERS];
	chu_rot_t stage_rot [CORDIC_ITERS];
	logic     rdy       [CORDIC_ITERS+1];

	localparam logic signed [ZW-1:0] HMAX_Z = ZW'(HEADING_MAX);

	logic signed [ZW-1:0] z_rnd;
	logic signed [HW-1:0] heading_d;
	chu_rot_t             last;

	assign rot_ready = rdy[0];
	assign rdy[CORDIC_ITERS] = !result.valid || result.ready;

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
		chu_rot_t src;
		logic     src_v;
		logic     vld_s;
		chu_rot_t rot_s;

		if (k == 0) begin : g_first
			assign src   = rot;
			assign src_v = rot_valid;
		end else begin : g_next
			assign src   = stage_rot[k-1];
			assign src_v = stage_v[k-1];
		end

		assign rdy[k] = !vld_s || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (rdy[k]) begin
				vld_s <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) rot_s <= cordic_iter(src, k);
		end

		assign stage_v[k]   = vld_s;
		assign stage_rot[k] = rot_s;
	end

	// Round Q.24 to Q3.13 and clamp, or force zero when flagged
	always_comb begin
		last  = stage_rot[CORDIC_ITERS-1];
		z_rnd = (last.z + ZW'(ROUND_BIAS)) >>> ROUND_SHIFT;
		if (last.force_zero) begin
			heading_d = '0;
		end else if (z_rnd > HMAX_Z) begin
			heading_d = HW'(HMAX_Z);
		end else if (z_rnd < -HMAX_Z) begin
			heading_d = HW'(-HMAX_Z);
		end else begin
			heading_d = HW'(z_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (rdy[CORDIC_ITERS]) begin
			result.valid <= stage_v[CORDIC_ITERS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[CORDIC_ITERS] && stage_v[CORDIC_ITERS-1]) begin
			result.heading <= heading_d;
		end
	end

	// Moving-apart flag only; force_zero also covers coincident projected points
	assign nc_flag = last.apart;

endmodule
